[hw/rtl/cts_pkg.sv]
// Shared types and constants for the calendar to seconds / uptime block.
// Request and result payloads, controller/datapath command and status groups.
// No dependencies.
package cts_pkg;

	typedef enum logic [1:0] {
		REQ_CAPTURE       = 2'd0,
		REQ_CAPTURE_UNSET = 2'd1,
		REQ_UPTIME        = 2'd2,
		REQ_NONE          = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day_of_month;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} req_t;

	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic [15:0] up_days;
		logic [4:0]  up_hours;
		logic [5:0]  up_minutes;
		logic [5:0]  up_seconds;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic year_step;
		logic month_step;
		logic mul;
		logic epoch;
		logic boot;
		logic div_step;
		logic out_write;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic year_done;
		logic month_done;
		logic uptime;
		logic div_last;
		logic out_free;
	} status_t;

	localparam logic [31:0] SECS_DAY  = 32'd86400;
	localparam logic [16:0] SECS_HOUR = 17'd3600;
	localparam logic [16:0] SECS_MIN  = 17'd60;

	// Leap counters start at 1970
	localparam logic [1:0] Y4_INIT   = 2'd2;
	localparam logic [6:0] Y100_INIT = 7'd70;
	localparam logic [8:0] Y400_INIT = 9'd370;
	localparam logic [6:0] Y100_LAST = 7'd99;
	localparam logic [8:0] Y400_LAST = 9'd399;

	localparam logic [15:0] DAYS_YEAR = 16'd365;
	localparam logic [15:0] DAYS_LEAP = 16'd366;
	localparam logic [3:0]  MONTH_CAP = 4'd13;

	localparam logic [5:0] DIV_60 = 6'd60;
	localparam logic [5:0] DIV_24 = 6'd24;

	// reciprocals: x / 60 = (x * RECIP_60) >> 37, x / 24 = (x * RECIP_24) >> 36,
	// exact for any 32-bit x
	localparam logic [31:0] RECIP_60 = 32'h8888_8889;
	localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		d = 5'd31;
		unique case (m)
			4'd2:    d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[hw/rtl/calendar_to_seconds_uptime_core.sv]
// Top level: calendar reading to seconds since 1970, boot capture and uptime.
// Depends on cts_pkg, cts_ctrl and cts_dp.
//
// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  ----------------------
// req      in         req_valid / req_stall   cts_pkg::req_t
// res      out        res_valid / res_stall   cts_pkg::res_t
//
// The time per request grows with the year and the month of the reading; an
// uptime query adds divisions by 60, 60 and 24 by reciprocal multiply, each a quotient then a remainder step.
// The year loop adds one year of days per cycle; the month loop one month.
// One request is in work at a time; req_stall is high from acceptance until
// the result is written to the output register, which then holds it while
// res_stall is high, so the next request can start behind it.
// Reset clears the controller, the output valid and the boot time (none held).
module calendar_to_seconds_uptime_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cts_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_stall,
	output cts_pkg::res_t  res
);

	cts_pkg::cmd_t    cmd;
	cts_pkg::status_t st;

	// sequencer: one-hot state, issues one command group per cycle
	cts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath: counters, multiplier, divider, boot register, output register
	cts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

[hw/rtl/cts_ctrl.sv]
// Sequencer for the calendar to seconds / uptime block.
// Uses cts_pkg command and status structs; drives cts_dp.
module cts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  cts_pkg::status_t  st,
	output cts_pkg::cmd_t     cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_YEAR  = 8'b0000_0010,
		S_MONTH = 8'b0000_0100,
		S_MUL   = 8'b0000_1000,
		S_EPOCH = 8'b0001_0000,
		S_BOOT  = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_YEAR;
				end
			end
			S_YEAR: begin
				if (st.year_done) begin
					state_d = S_MONTH;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			S_MONTH: begin
				if (st.month_done) begin
					state_d = S_MUL;
				end else begin
					cmd.month_step = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EPOCH;
			end
			S_EPOCH: begin
				cmd.epoch = 1'b1;
				state_d   = S_BOOT;
			end
			S_BOOT: begin
				cmd.boot = 1'b1;
				state_d  = st.uptime ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_write = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/cts_dp.sv]
// Datapath: day count, seconds, boot register, reciprocal divider, output register.
// Uses cts_pkg types; sequenced by cts_ctrl.
module cts_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cts_pkg::req_t     req,
	input  cts_pkg::cmd_t     cmd,
	output cts_pkg::status_t  st,
	output logic              res_valid,
	input  logic              res_stall,
	output cts_pkg::res_t     res
);

	cts_pkg::req_t  req_q;
	logic [15:0]    days_q;
	logic [6:0]     yr_idx_q;
	logic [1:0]     y4_q;
	logic [6:0]     y100_q;
	logic [8:0]     y400_q;
	logic [3:0]     mon_idx_q;
	logic [16:0]    tod_q;
	logic [31:0]    prod_q;
	logic [31:0]    epoch_q;
	logic [31:0]    boot_q;
	logic [31:0]    dvd_q;
	logic [31:0]    quo_q;
	logic           phase_q;
	logic [1:0]     stage_q;
	logic [15:0]    dd_q;
	logic [4:0]     hh_q;
	logic [5:0]     mm_q;
	logic [5:0]     ss_q;
	cts_pkg::res_t  res_q;
	logic           res_valid_q;

	logic        leap;
	logic [3:0]  mon_last;
	logic [16:0] day_sum;
	logic [31:0] day_prod;
	logic [16:0] tod_d;
	logic [5:0]  divisor;
	logic [31:0] recip;
	logic [63:0] recip_prod;
	logic [31:0] quo_n;
	logic [11:0] qd_lo;
	logic [5:0]  rem_n;

	// counters describe the year 1970 + yr_idx_q
	assign leap = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));

	assign mon_last = (req_q.month > cts_pkg::MONTH_CAP) ? cts_pkg::MONTH_CAP : req_q.month;

	assign day_sum  = {1'b0, days_q} + 17'(req_q.day_of_month);
	assign day_prod = 32'(day_sum) * cts_pkg::SECS_DAY;

	assign tod_d = 17'(req.hours) * cts_pkg::SECS_HOUR
	             + 17'(req.minutes) * cts_pkg::SECS_MIN
	             + 17'(req.seconds);

	// each division: quotient by reciprocal, then remainder
	assign divisor    = (stage_q == 2'd2) ? cts_pkg::DIV_24 : cts_pkg::DIV_60;
	assign recip      = (stage_q == 2'd2) ? cts_pkg::RECIP_24 : cts_pkg::RECIP_60;
	assign recip_prod = dvd_q * recip;
	assign quo_n      = (stage_q == 2'd2) ? {12'd0, recip_prod[55:36]}
	                                      : {5'd0, recip_prod[63:37]};
	// remainder is below 64, so the low six bits are enough
	assign qd_lo      = quo_q[5:0] * divisor;
	assign rem_n      = dvd_q[5:0] - qd_lo[5:0];

	assign st.year_done  = (yr_idx_q == req_q.year);
	assign st.month_done = (mon_idx_q >= mon_last);
	assign st.uptime     = (cts_pkg::req_kind_t'(req_q.req_type) == cts_pkg::REQ_UPTIME);
	assign st.div_last   = (stage_q == 2'd2) && phase_q;
	assign st.out_free   = !res_valid_q || !res_stall;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req;
			days_q    <= '0;
			yr_idx_q  <= '0;
			y4_q      <= cts_pkg::Y4_INIT;
			y100_q    <= cts_pkg::Y100_INIT;
			y400_q    <= cts_pkg::Y400_INIT;
			mon_idx_q <= 4'd1;
			tod_q     <= tod_d;
			dd_q      <= '0;
			hh_q      <= '0;
			mm_q      <= '0;
			ss_q      <= '0;
		end
		if (cmd.year_step) begin
			days_q   <= days_q + (leap ? cts_pkg::DAYS_LEAP : cts_pkg::DAYS_YEAR);
			yr_idx_q <= yr_idx_q + 7'd1;
			y4_q     <= y4_q + 2'd1;
			y100_q   <= (y100_q == cts_pkg::Y100_LAST) ? 7'd0 : y100_q + 7'd1;
			y400_q   <= (y400_q == cts_pkg::Y400_LAST) ? 9'd0 : y400_q + 9'd1;
		end
		if (cmd.month_step) begin
			days_q    <= days_q + 16'(cts_pkg::month_days(mon_idx_q, leap));
			mon_idx_q <= mon_idx_q + 4'd1;
		end
		if (cmd.mul) begin
			prod_q <= day_prod;
		end
		if (cmd.epoch) begin
			// day_of_month counts from 1
			epoch_q <= prod_q - cts_pkg::SECS_DAY + 32'(tod_q);
		end
		if (cmd.boot) begin
			dvd_q   <= epoch_q - boot_q;
			phase_q <= 1'b0;
			stage_q <= '0;
		end
		if (cmd.div_step) begin
			phase_q <= !phase_q;
			if (!phase_q) begin
				quo_q <= quo_n;
			end else begin
				dvd_q   <= quo_q;
				stage_q <= stage_q + 2'd1;
				unique case (stage_q)
					2'd0: ss_q <= rem_n;
					2'd1: mm_q <= rem_n;
					default: begin
						hh_q <= rem_n[4:0];
						dd_q <= quo_q[15:0];
					end
				endcase
			end
		end
		if (cmd.out_write) begin
			res_q <= '{epoch_seconds: epoch_q, up_days: dd_q, up_hours: hh_q,
			           up_minutes: mm_q, up_seconds: ss_q};
		end
	end

	// boot time: zero means none held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q <= '0;
		end else if (cmd.boot) begin
			priority if (cts_pkg::req_kind_t'(req_q.req_type) == cts_pkg::REQ_CAPTURE) begin
				boot_q <= epoch_q;
			end else if ((cts_pkg::req_kind_t'(req_q.req_type) == cts_pkg::REQ_CAPTURE_UNSET)
			             && (boot_q == 32'd0)) begin
				boot_q <= epoch_q;
			end else begin
				boot_q <= boot_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_write) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[hw/rtl/cts_checker.sv]
// Port-level checks for calendar_to_seconds_uptime_core, bound to the top level.
// Depends on cts_pkg.
module cts_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input cts_pkg::req_t  req,
	input logic           res_valid,
	input logic           res_stall,
	input cts_pkg::res_t  res
);

	// a held result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// a request takes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted back to back");

	// uptime parts stay within their ranges
	a_uptime_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.up_hours < 5'd24) && (res.up_minutes < 6'd60)
		              && (res.up_seconds < 6'd60))
		else $error("uptime part out of range");

	// no result can appear in the cycle right after an acceptance
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !res_valid |=> !res_valid)
		else $error("result appeared too early");

endmodule

bind calendar_to_seconds_uptime_core cts_checker u_cts_checker (.*);

[tb/tb_calendar_to_seconds_uptime_core.sv]
// Self-checking bench for calendar_to_seconds_uptime_core: calendar readings in, epoch/uptime out.
// Depends on cts_pkg and the core; holds its own epoch and uptime predictor with boot-time state.
// Stimulus: directed corner readings, then random well-formed sequences and full-width noise.
module tb_calendar_to_seconds_uptime_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cts_pkg::*;

	localparam logic [31:0] DAY_SECS   = 32'd86400;
	localparam logic [31:0] YEAR_SECS  = 32'd31536000;
	localparam int          N_RANDOM   = 1200;
	// The slowest request steps through 127 years and 12 months and then divides,
	// so reaching IDLE_LIMIT with no handshake can only mean a hang.
	localparam int          IDLE_LIMIT = 5000;
	localparam int          TAIL_WAIT  = 300;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  res_valid;
	logic  res_stall = 1'b0;
	res_t  res;

	calendar_to_seconds_uptime_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: calendar reading to seconds, boot-time register, uptime
	// ------------------------------------------------------------------
	logic [31:0] boot_time = '0;   // zero means no boot time held
	res_t        awaited_res[$];   // expected results, oldest first

	function automatic bit is_leap_off(int unsigned off);
		int unsigned y;
		y = 1970 + off;
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_length(int unsigned m, bit leap);
		case (m)
			2:             return leap ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	function automatic logic [31:0] calendar_seconds(req_t r);
		logic [31:0] s;
		int unsigned last;
		int unsigned i;
		s = 32'(r.year) * YEAR_SECS;
		for (i = 0; i < r.year; i++)
			if (is_leap_off(i))
				s += DAY_SECS;
		// months past December stop after all twelve; month 0 adds nothing
		last = (r.month > 13) ? 13 : r.month;
		for (i = 1; i < last; i++)
			s += DAY_SECS * month_length(i, is_leap_off(r.year));
		// day 0 takes a day off, wrapping
		s += (32'(r.day_of_month) - 32'd1) * DAY_SECS;
		s += 32'(r.hours) * 32'd3600;
		s += 32'(r.minutes) * 32'd60;
		s += 32'(r.seconds);
		return s;
	endfunction

	// Works out the result of one request and updates the boot register.
	function automatic res_t uptime_result(req_t r);
		res_t        e;
		logic [31:0] t;
		e = '0;
		e.epoch_seconds = calendar_seconds(r);
		case (r.req_type)
			REQ_CAPTURE:
				boot_time = e.epoch_seconds;
			REQ_CAPTURE_UNSET:
				if (boot_time == '0)
					boot_time = e.epoch_seconds;
			REQ_UPTIME: begin
				t = e.epoch_seconds - boot_time;
				e.up_seconds = 6'(t % 60);
				t = t / 60;
				e.up_minutes = 6'(t % 60);
				t = t / 60;
				e.up_hours = 5'(t % 24);
				e.up_days = 16'(t / 24);
			end
			default: ;   // unused selector: no state change, uptime fields stay zero
		endcase
		return e;
	endfunction

	// ------------------------------------------------------------------
	// Request source: pending readings and a parallel "wait for drain" flag
	// ------------------------------------------------------------------
	req_t pending_req[$];
	bit   drain_first[$];

	int n_sent = 0;
	int n_done = 0;     // written by the result checker only, nonblocking
	int n_fail = 0;
	int kind_cnt[4] = '{0, 0, 0, 0};
	int burst_left = 1;
	int gap_left = 0;

	function automatic req_t reading(req_kind_t k, int y, int mo, int d, int h, int mi,
			int s);
		req_t r;
		r.req_type     = k;
		r.year         = 7'(y);
		r.month        = 4'(mo);
		r.day_of_month = 5'(d);
		r.hours        = 5'(h);
		r.minutes      = 6'(mi);
		r.seconds      = 6'(s);
		return r;
	endfunction

	task automatic add_req(req_t r, bit drain);
		pending_req.push_back(r);
		drain_first.push_back(drain);
	endtask

	// Driver: bursts of back-to-back requests separated by random gaps.
	// Valid only drops once the current request has gone; never looks at res_stall.
	always @(posedge clk or negedge arst_n) begin
		bit took;
		bit settled;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			took = req_valid && !req_stall;
			if (took) begin
				awaited_res.push_back(uptime_result(req));
				kind_cnt[req.req_type]++;
				n_sent++;
			end
			// n_done is the pre-edge count, so a result taken this edge is
			// not yet counted here and keeps the hold in place
			settled = (n_sent == n_done);
			if (!req_valid || took) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_req.size() == 0) begin
					req_valid <= 1'b0;
				end else if (drain_first[0] && !settled) begin
					req_valid <= 1'b0;
				end else begin
					req <= pending_req.pop_front();
					void'(drain_first.pop_front());
					req_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						// a quarter of bursts run straight into the next one
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: stall pattern changes mode every so often
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int mode_left = 200;

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				n_done <= n_done + 1;
				if (awaited_res.size() == 0) begin
					$error("result with nothing expected: epoch_seconds %0d", res.epoch_seconds);
					n_fail++;
				end else begin
					e = awaited_res.pop_front();
					if (res.epoch_seconds !== e.epoch_seconds) begin
						$error("epoch_seconds: expected %0d, got %0d", e.epoch_seconds,
							res.epoch_seconds);
						n_fail++;
					end
					if (res.up_days !== e.up_days) begin
						$error("up_days: expected %0d, got %0d", e.up_days, res.up_days);
						n_fail++;
					end
					if (res.up_hours !== e.up_hours) begin
						$error("up_hours: expected %0d, got %0d", e.up_hours, res.up_hours);
						n_fail++;
					end
					if (res.up_minutes !== e.up_minutes) begin
						$error("up_minutes: expected %0d, got %0d", e.up_minutes,
							res.up_minutes);
						n_fail++;
					end
					if (res.up_seconds !== e.up_seconds) begin
						$error("up_seconds: expected %0d, got %0d", e.up_seconds,
							res.up_seconds);
						n_fail++;
					end
				end
			end
			// mode 0: never stall, 1: coin toss, 2: mostly stalled
			mode_left--;
			if (mode_left <= 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 400);
			end
			case (stall_mode)
				0:       res_stall <= 1'b0;
				1:       res_stall <= 1'($urandom_range(0, 1));
				default: res_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Watchdog: too long without any handshake on either channel
	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("timeout: %0d cycles without a handshake", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		req_t        r;
		logic [63:0] raw;
		int          y;
		int          mo;
		int          pick;
		req_kind_t   k;

		// Directed: boot unset, capture-if-unset, leap rules, wide and odd fields
		add_req(reading(REQ_UPTIME, 0, 1, 1, 0, 0, 0), 0);          // epoch zero, no boot
		add_req(reading(REQ_CAPTURE_UNSET, 0, 1, 1, 0, 0, 0), 0);   // stores zero: still unset
		add_req(reading(REQ_CAPTURE_UNSET, 30, 2, 29, 12, 30, 45), 0); // 29 Feb 2000
		add_req(reading(REQ_CAPTURE_UNSET, 40, 6, 1, 0, 0, 0), 0);  // boot held, ignored
		add_req(reading(REQ_UPTIME, 30, 3, 1, 0, 0, 0), 0);         // day after leap day
		add_req(reading(REQ_UPTIME, 99, 12, 31, 23, 59, 59), 0);
		add_req(reading(REQ_NONE, 127, 15, 31, 31, 63, 63), 0);      // all ones, no effect
		add_req(reading(REQ_UPTIME, 2, 0, 0, 0, 0, 0), 0);          // month zero, day zero
		add_req(reading(REQ_UPTIME, 30, 13, 1, 0, 0, 0), 0);        // months past December
		add_req(reading(REQ_UPTIME, 30, 14, 5, 0, 0, 0), 0);
		add_req(reading(REQ_UPTIME, 31, 15, 5, 31, 63, 63), 0);     // wide time fields
		add_req(reading(REQ_UPTIME, 0, 1, 1, 0, 0, 0), 0);          // earlier than boot
		add_req(reading(REQ_CAPTURE, 127, 15, 31, 31, 63, 63), 1);  // late boot time: later uptimes wrap
		add_req(reading(REQ_UPTIME, 0, 1, 1, 0, 0, 0), 0);
		add_req(reading(REQ_UPTIME, 100, 2, 28, 0, 0, 1), 0);
		add_req(reading(REQ_CAPTURE, 0, 1, 1, 0, 0, 0), 0);         // boot back to none
		add_req(reading(REQ_CAPTURE_UNSET, 2, 2, 29, 1, 2, 3), 0);  // 1972 leap, now stored
		add_req(reading(REQ_UPTIME, 26, 1, 1, 0, 0, 0), 0);
		add_req(reading(REQ_UPTIME, 2, 2, 29, 1, 2, 3), 0);         // zero uptime
		add_req(reading(REQ_UPTIME, 2, 2, 29, 1, 3, 2), 0);
		add_req(reading(REQ_CAPTURE, 0, 0, 31, 0, 0, 0), 0);

		// Random: mostly well-formed readings, some full-width noise
		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 99) < 15) begin
				raw = {$urandom, $urandom};
				r = raw[$bits(req_t)-1:0];
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50)      k = REQ_UPTIME;
				else if (pick < 68) k = REQ_CAPTURE;
				else if (pick < 92) k = REQ_CAPTURE_UNSET;
				else                k = REQ_NONE;
				y = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 99);
				mo = $urandom_range(1, 12);
				r = reading(k, y, mo, $urandom_range(1, month_length(mo, is_leap_off(y))),
					$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
				// now and then drop the boot time back to none
				if (k == REQ_CAPTURE && $urandom_range(0, 5) == 0)
					r = reading(REQ_CAPTURE, 0, 1, 1, 0, 0, 0);
			end
			add_req(r, (n == 0) || ($urandom_range(0, 99) == 0));
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_req.size() != 0 || req_valid)
			@(posedge clk);
		while (awaited_res.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("%0d requests checked: %0d capture, %0d capture-if-unset, %0d uptime, %0d unused",
			n_sent, kind_cnt[REQ_CAPTURE], kind_cnt[REQ_CAPTURE_UNSET], kind_cnt[REQ_UPTIME],
			kind_cnt[REQ_NONE]);
		$display("%0d results received, %0d mismatches", n_done, n_fail);
		if (n_fail == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/cts_pkg.sv
hw/rtl/cts_ctrl.sv
hw/rtl/cts_dp.sv
hw/rtl/calendar_to_seconds_uptime_core.sv
hw/rtl/cts_checker.sv
tb/tb_calendar_to_seconds_uptime_core.sv
